@@ rtl/core/cdse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// CAN DBC signal extraction package
// Widths, register indexes and bit-order helpers shared by the extraction
// unit, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package cdse_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int ID_W        = 29;
    localparam int LEN_W       = 4;
    localparam int DATA_W      = 64;
    localparam int VALUE_W     = 64;
    localparam int START_W     = 6;
    localparam int SIGLEN_W    = 7;
    localparam int SCALE_W     = 32;
    localparam int OFFSET_W    = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_ID      = 3'd0,
        CFG_START_BIT     = 3'd1,
        CFG_SIG_LENGTH    = 3'd2,
        CFG_LITTLE_ENDIAN = 3'd3,
        CFG_SIGN_EXTEND   = 3'd4,
        CFG_SCALE_Q16     = 3'd5,
        CFG_OFFSET_Q16    = 3'd6
    } t_cfg_idx;

    // Reverses the bit order inside each byte, keeping the byte order.
    function automatic logic [DATA_W-1:0] rev_in_bytes(input logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] r;
        for (int b = 0; b < DATA_W / 8; b++) begin
            for (int k = 0; k < 8; k++) begin
                r[b*8 + k] = d[b*8 + 7 - k];
            end
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] rev_word(input logic [DATA_W-1:0] d);
        logic [DATA_W-1:0] r;
        for (int k = 0; k < DATA_W; k++) begin
            r[k] = d[DATA_W - 1 - k];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/cdse_frame_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// CAN frame channel
// Valid/ready channel that carries one classic CAN frame per transaction.
// ----------------------------------------------------------------------------
interface cdse_frame_if;
    import cdse_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_len;
    logic [DATA_W-1:0] frame_data;

    modport source (output valid, output frame_id, output frame_len, output frame_data,
                    input ready);
    modport sink   (input valid, input frame_id, input frame_len, input frame_data,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/core/cdse_value_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Physical value channel
// Valid/ready channel that carries one scaled signal value per transaction.
// ----------------------------------------------------------------------------
interface cdse_value_if;
    import cdse_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] phys_value;

    modport source (output valid, output phys_value, input ready);
    modport sink   (input valid, input phys_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/can_dbc_signal_extract_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// CAN DBC signal extraction unit
// Extracts one DBC signal from matching CAN frames, scales it and reports
// the physical value whenever it changes.
// ----------------------------------------------------------------------------
// Usage:
//   i_frame carries one CAN frame per transaction. Frames whose identifier
//   differs from match_id are consumed and dropped. o_value carries the
//   saturated Q47.16 physical value; a transaction is issued only for the
//   first value after reset and whenever the value differs from the last
//   one issued.
//   Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data while no
//   frame is in flight; an index beyond offset_q16 is ignored.
//   Each frame passes through the input register, field gather, partial
//   products, sum and saturation, then the output register. One frame can
//   be taken every cycle unless the pipeline is held by a stalled o_value.
//   If o_value stalls, the pipeline keeps filling its empty stages and
//   frames whose value does not change still drain; i_frame.ready falls
//   once a changed value is blocked behind the waiting result.
//   Synchronous reset restores the register defaults, empties the pipeline
//   and forgets the last reported value.
// ----------------------------------------------------------------------------
module can_dbc_signal_extract_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [cdse_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cdse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cdse_frame_if.sink                        i_frame,
    cdse_value_if.source                      o_value
);
    import cdse_pkg::*;

    // Configuration registers
    logic [ID_W-1:0]            r_match_id;
    logic [START_W-1:0]         r_start_bit;
    logic [SIGLEN_W-1:0]        r_sig_length;
    logic                       r_little_endian;
    logic                       r_sign_extend;
    logic signed [SCALE_W-1:0]  r_scale_q16;
    logic signed [OFFSET_W-1:0] r_offset_q16;

    // Stage 1: input register
    logic                  r_s1_v;
    logic [ID_W-1:0]       r_s1_id;
    logic [LEN_W-1:0]      r_s1_len;
    logic [DATA_W-1:0]     r_s1_data;
    // Stage 2: gathered raw field
    logic                  r_s2_v;
    logic [DATA_W-1:0]     r_s2_raw;
    logic                  r_s2_neg;
    // Stage 3: partial products
    logic                  r_s3_v;
    logic signed [64:0]    r_s3_pp_lo;
    logic signed [64:0]    r_s3_pp_hi;
    // Stage 4: saturated value
    logic                  r_s4_v;
    logic [VALUE_W-1:0]    r_s4_val;
    // Output register and change detection
    logic                  r_ov;
    logic [VALUE_W-1:0]    r_ovalue;
    logic [VALUE_W-1:0]    r_last;
    logic                  r_have;

    logic                  rdy1, rdy2, rdy3, rdy4, rdy_o, emit4;

    // Gather signals
    logic [LEN_W-1:0]      w_eff;
    logic [SIGLEN_W-1:0]   w_len;
    logic [DATA_W-1:0]     w_byte_mask;
    logic [DATA_W-1:0]     w_data_m;
    logic [DATA_W-1:0]     w_len_mask;
    logic [START_W-1:0]    w_drop;
    logic [START_W-1:0]    w_mot_start;
    logic [DATA_W-1:0]     w_mot_seq;
    logic [DATA_W-1:0]     w_raw0;
    logic [START_W-1:0]    w_top;
    logic                  w_match;
    logic [DATA_W-1:0]     n_raw;
    logic                  n_neg;

    logic signed [32:0]    w_lo_op;
    logic signed [32:0]    w_hi_op;
    logic signed [64:0]    n_pp_lo;
    logic signed [64:0]    n_pp_hi;

    logic signed [97:0]    w_sum;
    logic                  w_in_range;
    logic [VALUE_W-1:0]    n_val;

    // Handshake: each stage takes a new item when empty or when it moves on.
    // A stage-4 item whose value is unchanged is dropped without the output.
    assign rdy_o         = !r_ov || o_value.ready;
    assign emit4         = !r_have || (r_s4_val != r_last);
    assign rdy4          = !r_s4_v || !emit4 || rdy_o;
    assign rdy3          = !r_s3_v || rdy4;
    assign rdy2          = !r_s2_v || rdy3;
    assign rdy1          = !r_s1_v || rdy2;
    assign i_frame.ready = rdy1;

    assign o_value.valid      = r_ov;
    assign o_value.phys_value = r_ovalue;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_id      <= '0;
            r_start_bit     <= '0;
            r_sig_length    <= SIGLEN_W'(8);
            r_little_endian <= 1'b1;
            r_sign_extend   <= 1'b0;
            r_scale_q16     <= SCALE_W'(65536);
            r_offset_q16    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MATCH_ID:      r_match_id      <= i_cfg_data[ID_W-1:0];
                CFG_START_BIT:     r_start_bit     <= i_cfg_data[START_W-1:0];
                CFG_SIG_LENGTH:    r_sig_length    <= i_cfg_data[SIGLEN_W-1:0];
                CFG_LITTLE_ENDIAN: r_little_endian <= i_cfg_data[0];
                CFG_SIGN_EXTEND:   r_sign_extend   <= i_cfg_data[0];
                CFG_SCALE_Q16:     r_scale_q16     <= $signed(i_cfg_data[SCALE_W-1:0]);
                CFG_OFFSET_Q16:    r_offset_q16    <= $signed(i_cfg_data[OFFSET_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Field gather. Motorola order visits the bytes upward and each byte from
    // bit 7 down, so after bit-reversing every byte it is a plain upward scan
    // starting at the reversed position of the start bit.
    always_comb begin
        w_match = (r_s1_id == r_match_id);
        w_eff   = (r_s1_len > LEN_W'(FRAME_BYTES)) ? LEN_W'(FRAME_BYTES) : r_s1_len;
        if (r_sig_length == '0) begin
            w_len = SIGLEN_W'(1);
        end else if (r_sig_length > SIGLEN_W'(DATA_W)) begin
            w_len = SIGLEN_W'(DATA_W);
        end else begin
            w_len = r_sig_length;
        end
        for (int b = 0; b < FRAME_BYTES; b++) begin
            w_byte_mask[b*8 +: 8] = (LEN_W'(b) < w_eff) ? 8'hFF : 8'h00;
        end
        w_data_m    = r_s1_data & w_byte_mask;
        w_drop      = START_W'(SIGLEN_W'(DATA_W) - w_len);
        w_len_mask  = {DATA_W{1'b1}} >> w_drop;
        w_mot_start = {r_start_bit[5:3], ~r_start_bit[2:0]};
        w_mot_seq   = rev_in_bytes(w_data_m) >> w_mot_start;
        if (r_little_endian) begin
            w_raw0 = (w_data_m >> r_start_bit) & w_len_mask;
        end else begin
            w_raw0 = rev_word(w_mot_seq) >> w_drop;
        end
        w_top = START_W'(w_len - SIGLEN_W'(1));
        n_raw = w_raw0;
        if (r_sign_extend && (w_len != SIGLEN_W'(DATA_W)) && w_raw0[w_top]) begin
            n_raw = w_raw0 | ~w_len_mask;
        end
        n_neg = r_sign_extend && n_raw[DATA_W-1];
    end

    // The 65-bit signed raw value is split into a signed upper half and an
    // unsigned lower half, each multiplied by the 32-bit scale.
    assign w_lo_op = $signed({1'b0, r_s2_raw[31:0]});
    assign w_hi_op = $signed({r_s2_neg, r_s2_raw[63:32]});
    assign n_pp_lo = 65'(w_lo_op) * 65'(r_scale_q16);
    assign n_pp_hi = 65'(w_hi_op) * 65'(r_scale_q16);

    assign w_sum = $signed({r_s3_pp_hi[64], r_s3_pp_hi, 32'b0})
                 + $signed({{33{r_s3_pp_lo[64]}}, r_s3_pp_lo})
                 + $signed({{34{r_offset_q16[63]}}, r_offset_q16});
    assign w_in_range = (&w_sum[97:63]) || !(|w_sum[97:63]);

    always_comb begin
        if (w_in_range) begin
            n_val = w_sum[63:0];
        end else if (w_sum[97]) begin
            n_val = {1'b1, {(VALUE_W-1){1'b0}}};
        end else begin
            n_val = {1'b0, {(VALUE_W-1){1'b1}}};
        end
    end

    // Pipeline valid bits and change-detection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_ov   <= 1'b0;
            r_have <= 1'b0;
            r_last <= '0;
        end else begin
            if (rdy1) r_s1_v <= i_frame.valid;
            if (rdy2) r_s2_v <= r_s1_v && w_match;
            if (rdy3) r_s3_v <= r_s2_v;
            if (rdy4) r_s4_v <= r_s3_v;
            if (rdy_o) r_ov <= r_s4_v && emit4;
            if (r_s4_v && emit4 && rdy_o) begin
                r_have <= 1'b1;
                r_last <= r_s4_val;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_id   <= i_frame.frame_id;
            r_s1_len  <= i_frame.frame_len;
            r_s1_data <= i_frame.frame_data;
        end
        if (rdy2) begin
            r_s2_raw <= n_raw;
            r_s2_neg <= n_neg;
        end
        if (rdy3) begin
            r_s3_pp_lo <= n_pp_lo;
            r_s3_pp_hi <= n_pp_hi;
        end
        if (rdy4) begin
            r_s4_val <= n_val;
        end
        if (rdy_o) begin
            r_ovalue <= r_s4_val;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/cdse_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// CAN DBC signal extraction checker
// Port-level checks on the result channel, bound to the extraction unit.
// ----------------------------------------------------------------------------
module cdse_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [cdse_pkg::VALUE_W-1:0] i_out_value
);
    import cdse_pkg::*;

    logic               r_seen;
    logic [VALUE_W-1:0] r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_prev <= '0;
        end else if (i_out_valid && i_out_ready) begin
            r_seen <= 1'b1;
            r_prev <= i_out_value;
        end
    end

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result keeps its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("stalled result changed");

    // Consecutive results always differ.
    a_changed_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && r_seen |-> i_out_value != r_prev)
        else $error("repeated result value");

endmodule

bind can_dbc_signal_extract_unit cdse_checker u_cdse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_value.valid),
    .i_out_ready (o_value.ready),
    .i_out_value (o_value.phys_value)
);
`default_nettype wire
